/* hdl/ycs_pkg.sv */
package ycs_pkg;

  // Fixed field widths of the pixel and register interfaces
  localparam int VALUE_WIDTH     = 28;
  localparam int LUMA_WIDTH      = 27;
  localparam int CFG_INDEX_WIDTH = 2;

  // Register map
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LUMA = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_LUMA = CFG_INDEX_WIDTH'(1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [LUMA_WIDTH-1:0]         luma_t;

  typedef struct packed {
    value_t in_red;
    value_t in_green;
    value_t in_blue;
    value_t orange_shift;
    value_t green_shift;
    value_t luma_shift;
  } pixel_in_t;

  typedef struct packed {
    value_t out_red;
    value_t out_green;
    value_t out_blue;
    logic   divide_error;
  } pixel_out_t;

endpackage

/* hdl/ycocg_color_shift.sv */
// Channel   | Handshake                | Payload
// ----------+--------------------------+-------------------------------------
// input     | in_valid / in_stall      | in_data  (pixel_in_t: RGB + shifts)
// output    | out_valid / out_stall    | out_data (pixel_out_t: RGB + error)
// config    | cfg_valid / cfg_ready    | cfg_index, cfg_data (luma clamps)
//
// One transaction per clock sustained while out_stall is low; results come out of
// the 27-stage restoring divider that scales both chromas
// by new luma over old luma (one quotient bit per stage, both chromas side by side).
// Reset (rst, synchronous) clears all valid bits and loads the clamp registers.
// An output stall holds only the run of full stages ahead of it; empty stages
// close up, so input keeps being taken while a result waits if any stage is empty.
module ycocg_color_shift #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ycs_pkg::pixel_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ycs_pkg::pixel_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ycs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  ycs_pkg::luma_t                      cfg_data
);
  import ycs_pkg::*;

  localparam int SUM_WIDTH   = VALUE_WIDTH + 3;
  localparam int SHIFT_WIDTH = VALUE_WIDTH + 1;
  localparam int MAG_WIDTH   = VALUE_WIDTH;
  localparam int REM_WIDTH   = MAG_WIDTH + 1;
  localparam int DIV_BASE    = 2;
  localparam int F_STAGE     = DIV_BASE + LUMA_WIDTH + 1;
  localparam int G_STAGE     = F_STAGE + 1;
  localparam int OUT_STAGE   = G_STAGE + 1;
  localparam int NUM_STAGES  = OUT_STAGE + 1;

  localparam luma_t MAX_LUMA_RESET = luma_t'(1) << FRAC_BITS;

  typedef logic [MAG_WIDTH-1:0]          mag_t;
  typedef logic signed [SHIFT_WIDTH-1:0] shifted_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [LUMA_WIDTH:0]    chroma_t;

  typedef struct packed {
    value_t y;
    value_t co;
    value_t cg;
    value_t red;
    value_t green;
    value_t blue;
    value_t orange_shift;
    value_t green_shift;
    value_t luma_shift;
  } stage_a_t;

  typedef struct packed {
    shifted_t ny_raw;
    shifted_t co_sum;
    shifted_t cg_sum;
    mag_t     m;
    logic     y_neg;
    logic     zero;
    value_t   red;
    value_t   green;
    value_t   blue;
  } stage_b_t;

  typedef struct packed {
    logic [REM_WIDTH-1:0] rem;
    luma_t                quo;
    mag_t                 a;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    luma_t  ny;
    mag_t   m;
    logic   zero;
    value_t red;
    value_t green;
    value_t blue;
    lane_t  co;
    lane_t  cg;
  } div_stage_t;

  typedef struct packed {
    luma_t   ny;
    logic    zero;
    value_t  red;
    value_t  green;
    value_t  blue;
    chroma_t co2;
    chroma_t cg2;
  } stage_f_t;

  typedef struct packed {
    logic   zero;
    value_t red;
    value_t green;
    value_t blue;
    sum_t   red_sum;
    sum_t   green_sum;
    sum_t   blue_sum;
  } stage_g_t;

  // Set up one chroma lane: magnitude capped at |Y|, sign of the quotient
  function automatic lane_t lane_init(shifted_t s, mag_t m, logic y_neg);
    logic [SHIFT_WIDTH-1:0] mag;
    lane_t                  l;
    mag   = s[SHIFT_WIDTH-1] ? SHIFT_WIDTH'(-s) : SHIFT_WIDTH'(s);
    l.rem = '0;
    l.quo = '0;
    l.neg = s[SHIFT_WIDTH-1] ^ y_neg;
    l.a   = (mag > SHIFT_WIDTH'(m)) ? m : mag_t'(mag);
    return l;
  endfunction

  // One quotient bit of floor(a * ny / m)
  function automatic lane_t lane_step(lane_t l, mag_t c, logic b_bit);
    logic [REM_WIDTH-1:0] rem_v;
    luma_t                quo_v;
    lane_t                r;
    rem_v = {l.rem[REM_WIDTH-2:0], 1'b0};
    quo_v = {l.quo[LUMA_WIDTH-2:0], 1'b0};
    if (rem_v >= REM_WIDTH'(c)) begin
      rem_v = rem_v - REM_WIDTH'(c);
      quo_v = quo_v + luma_t'(1);
    end
    if (b_bit) begin
      rem_v = rem_v + REM_WIDTH'(l.a);
      if (rem_v >= REM_WIDTH'(c)) begin
        rem_v = rem_v - REM_WIDTH'(c);
        quo_v = quo_v + luma_t'(1);
      end
    end
    r     = l;
    r.rem = rem_v;
    r.quo = quo_v;
    return r;
  endfunction

  function automatic chroma_t apply_sign(luma_t q, logic neg);
    chroma_t q_s;
    q_s = signed'({1'b0, q});
    return neg ? -q_s : q_s;
  endfunction

  function automatic value_t saturate(sum_t v);
    value_t res;
    if ((v[SUM_WIDTH-1:VALUE_WIDTH-1] == '0) || (v[SUM_WIDTH-1:VALUE_WIDTH-1] == '1)) begin
      res = value_t'(v[VALUE_WIDTH-1:0]);
    end else if (v[SUM_WIDTH-1]) begin
      res = value_t'({1'b1, {(VALUE_WIDTH-1){1'b0}}});
    end else begin
      res = value_t'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    end
    return res;
  endfunction

  luma_t                 min_luma;
  luma_t                 max_luma;
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] hold;
  stage_a_t              stage_a;
  stage_a_t              stage_a_next;
  stage_b_t              stage_b;
  stage_b_t              stage_b_next;
  div_stage_t            div_pipe [LUMA_WIDTH+1];
  div_stage_t            div_next [LUMA_WIDTH+1];
  stage_f_t              stage_f;
  stage_f_t              stage_f_next;
  stage_g_t              stage_g;
  stage_g_t              stage_g_next;
  pixel_out_t            out_data_next;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_luma <= '0;
      max_luma <= MAX_LUMA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_LUMA: min_luma <= cfg_data;
        REG_MAX_LUMA: max_luma <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold a stage only when it and every stage ahead of it are full and the output stalls
  always_comb begin
    hold[OUT_STAGE] = stage_valid[OUT_STAGE] & out_stall;
    for (int i = OUT_STAGE - 1; i >= 0; i--) begin
      hold[i] = stage_valid[i] & hold[i+1];
    end
  end

  assign in_stall  = hold[0];
  assign out_valid = stage_valid[OUT_STAGE];

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (!hold[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (!hold[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  // Stage A: RGB to YCoCg
  always_comb begin
    sum_t r_ext;
    sum_t g_ext;
    sum_t b_ext;
    sum_t luma_sum;
    sum_t co_diff;
    sum_t cg_diff;
    r_ext    = SUM_WIDTH'(in_data.in_red);
    g_ext    = SUM_WIDTH'(in_data.in_green);
    b_ext    = SUM_WIDTH'(in_data.in_blue);
    luma_sum = r_ext + (g_ext <<< 1) + b_ext;
    co_diff  = r_ext - b_ext;
    cg_diff  = (g_ext <<< 1) - r_ext - b_ext;
    stage_a_next.y            = value_t'(luma_sum >>> 2);
    stage_a_next.co           = value_t'(co_diff >>> 1);
    stage_a_next.cg           = value_t'(cg_diff >>> 2);
    stage_a_next.red          = in_data.in_red;
    stage_a_next.green        = in_data.in_green;
    stage_a_next.blue         = in_data.in_blue;
    stage_a_next.orange_shift = in_data.orange_shift;
    stage_a_next.green_shift  = in_data.green_shift;
    stage_a_next.luma_shift   = in_data.luma_shift;
  end

  // Stage B: add shifts, take |Y|
  always_comb begin
    stage_b_next.ny_raw = SHIFT_WIDTH'(stage_a.y) + SHIFT_WIDTH'(stage_a.luma_shift);
    stage_b_next.co_sum = SHIFT_WIDTH'(stage_a.co) + SHIFT_WIDTH'(stage_a.orange_shift);
    stage_b_next.cg_sum = SHIFT_WIDTH'(stage_a.cg) + SHIFT_WIDTH'(stage_a.green_shift);
    stage_b_next.m      = stage_a.y[VALUE_WIDTH-1] ? mag_t'(-stage_a.y) : mag_t'(stage_a.y);
    stage_b_next.y_neg  = stage_a.y[VALUE_WIDTH-1];
    stage_b_next.zero   = (stage_a.y == '0);
    stage_b_next.red    = stage_a.red;
    stage_b_next.green  = stage_a.green;
    stage_b_next.blue   = stage_a.blue;
  end

  // Stage C (divider entry): clamp new luma, max clamp last; then one bit per stage
  always_comb begin
    shifted_t lo;
    shifted_t t;
    lo = signed'(SHIFT_WIDTH'(min_luma));
    t  = (stage_b.ny_raw < lo) ? lo : stage_b.ny_raw;
    div_next[0].ny    = (t > signed'(SHIFT_WIDTH'(max_luma))) ? max_luma : luma_t'(t);
    div_next[0].m     = stage_b.m;
    div_next[0].zero  = stage_b.zero;
    div_next[0].red   = stage_b.red;
    div_next[0].green = stage_b.green;
    div_next[0].blue  = stage_b.blue;
    div_next[0].co    = lane_init(stage_b.co_sum, stage_b.m, stage_b.y_neg);
    div_next[0].cg    = lane_init(stage_b.cg_sum, stage_b.m, stage_b.y_neg);
    for (int k = 0; k < LUMA_WIDTH; k++) begin
      div_next[k+1]    = div_pipe[k];
      div_next[k+1].co = lane_step(div_pipe[k].co, div_pipe[k].m,
                                   div_pipe[k].ny[LUMA_WIDTH-1-k]);
      div_next[k+1].cg = lane_step(div_pipe[k].cg, div_pipe[k].m,
                                   div_pipe[k].ny[LUMA_WIDTH-1-k]);
    end
  end

  // Stage F: restore chroma signs
  always_comb begin
    stage_f_next.ny    = div_pipe[LUMA_WIDTH].ny;
    stage_f_next.zero  = div_pipe[LUMA_WIDTH].zero;
    stage_f_next.red   = div_pipe[LUMA_WIDTH].red;
    stage_f_next.green = div_pipe[LUMA_WIDTH].green;
    stage_f_next.blue  = div_pipe[LUMA_WIDTH].blue;
    stage_f_next.co2   = apply_sign(div_pipe[LUMA_WIDTH].co.quo, div_pipe[LUMA_WIDTH].co.neg);
    stage_f_next.cg2   = apply_sign(div_pipe[LUMA_WIDTH].cg.quo, div_pipe[LUMA_WIDTH].cg.neg);
  end

  // Stage G: YCoCg back to RGB
  always_comb begin
    sum_t ny_ext;
    sum_t co_ext;
    sum_t cg_ext;
    ny_ext = SUM_WIDTH'(signed'({1'b0, stage_f.ny}));
    co_ext = SUM_WIDTH'(stage_f.co2);
    cg_ext = SUM_WIDTH'(stage_f.cg2);
    stage_g_next.zero      = stage_f.zero;
    stage_g_next.red       = stage_f.red;
    stage_g_next.green     = stage_f.green;
    stage_g_next.blue      = stage_f.blue;
    stage_g_next.red_sum   = ny_ext + co_ext - cg_ext;
    stage_g_next.green_sum = ny_ext + cg_ext;
    stage_g_next.blue_sum  = ny_ext - co_ext - cg_ext;
  end

  // Output: saturate, or pass the color through on zero luma
  always_comb begin
    out_data_next.out_red      = stage_g.zero ? stage_g.red : saturate(stage_g.red_sum);
    out_data_next.out_green    = stage_g.zero ? stage_g.green : saturate(stage_g.green_sum);
    out_data_next.out_blue     = stage_g.zero ? stage_g.blue : saturate(stage_g.blue_sum);
    out_data_next.divide_error = stage_g.zero;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      stage_a <= stage_a_next;
    end
    if (!hold[1]) begin
      stage_b <= stage_b_next;
    end
    for (int i = 0; i <= LUMA_WIDTH; i++) begin
      if (!hold[DIV_BASE+i]) begin
        div_pipe[i] <= div_next[i];
      end
    end
    if (!hold[F_STAGE]) begin
      stage_f <= stage_f_next;
    end
    if (!hold[G_STAGE]) begin
      stage_g <= stage_g_next;
    end
    if (!hold[OUT_STAGE]) begin
      out_data <= out_data_next;
    end
  end

  // Input is held back only when the whole pipeline is full behind a stalled output
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && (stage_valid == '1)))
    else $error("input stalled while pipeline has room");

  // New luma never exceeds the upper clamp
  assert property (@(posedge clk) disable iff (rst)
    stage_valid[DIV_BASE] |-> (div_pipe[0].ny <= max_luma))
    else $error("clamped luma above max_luma");

  // Divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid[F_STAGE-1] && !div_pipe[LUMA_WIDTH].zero) |->
      ((div_pipe[LUMA_WIDTH].co.rem < REM_WIDTH'(div_pipe[LUMA_WIDTH].m)) &&
       (div_pipe[LUMA_WIDTH].cg.rem < REM_WIDTH'(div_pipe[LUMA_WIDTH].m))))
    else $error("divider remainder out of range");

  // Scaled chroma magnitude never exceeds the new luma
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid[F_STAGE-1] && !div_pipe[LUMA_WIDTH].zero) |->
      ((div_pipe[LUMA_WIDTH].co.quo <= div_pipe[LUMA_WIDTH].ny) &&
       (div_pipe[LUMA_WIDTH].cg.quo <= div_pipe[LUMA_WIDTH].ny)))
    else $error("scaled chroma above new luma");

endmodule

/* bench/ycocg_color_shift_test.sv */
module ycocg_color_shift_test;
  import ycs_pkg::*;

  localparam int     FRAC        = 16;
  localparam longint ONE         = longint'(1) << FRAC;
  localparam longint VALUE_HI    = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
  localparam longint VALUE_LO    = -VALUE_HI - 1;
  localparam luma_t  LUMA_TOP    = '1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = CFG_INDEX_WIDTH'(3);
  localparam int     PIPE_SETTLE = 40;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     PHASE_COUNT = 6;
  localparam int     PHASE_ITEMS = 265;

  // Luma clamp settings per phase: full range, typical, min above max,
  // both zero, both at the top, and a wide window
  localparam luma_t PHASE_MIN [PHASE_COUNT] = '{
    luma_t'(0), luma_t'(ONE / 4), luma_t'(2 * ONE), luma_t'(0), LUMA_TOP, luma_t'(ONE / 8)
  };
  localparam luma_t PHASE_MAX [PHASE_COUNT] = '{
    LUMA_TOP, luma_t'(ONE), luma_t'(ONE), luma_t'(0), LUMA_TOP, luma_t'(3 * ONE)
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  pixel_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pixel_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  luma_t      cfg_data  = '0;

  luma_t      luma_floor   = '0;
  luma_t      luma_ceiling = luma_t'(ONE);

  pixel_in_t  pixel_backlog[$];
  pixel_out_t expected_colors[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int issued_count   = 0;
  int checked_count  = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  ycocg_color_shift #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturate to the signed output field range
  function automatic value_t clip_value(longint v);
    if (v > VALUE_HI) return value_t'(VALUE_HI);
    if (v < VALUE_LO) return value_t'(VALUE_LO);
    return value_t'(v);
  endfunction

  // Scale a shifted chroma by new luma over old luma, truncating toward zero;
  // the magnitude is capped at |luma| so the result stays within +/- new luma
  function automatic longint scaled_chroma(longint chroma, longint luma, longint new_luma);
    longint mag_luma;
    longint mag_chroma;
    longint quotient;
    mag_luma   = (luma < 0) ? -luma : luma;
    mag_chroma = (chroma < 0) ? -chroma : chroma;
    if (mag_chroma > mag_luma) mag_chroma = mag_luma;
    quotient = (mag_chroma * new_luma) / mag_luma;
    return ((chroma < 0) != (luma < 0)) ? -quotient : quotient;
  endfunction

  // Expected adjusted color for one pixel under the given luma clamps
  function automatic pixel_out_t adjust_color(pixel_in_t px, luma_t lo, luma_t hi);
    longint     red;
    longint     green;
    longint     blue;
    longint     luma;
    longint     co;
    longint     cg;
    longint     new_luma;
    longint     co_new;
    longint     cg_new;
    pixel_out_t res;
    red   = longint'($signed(px.in_red));
    green = longint'($signed(px.in_green));
    blue  = longint'($signed(px.in_blue));
    luma  = (red + 2 * green + blue) >>> 2;
    co    = (red - blue) >>> 1;
    cg    = (2 * green - red - blue) >>> 2;
    // Zero luma: flag it and pass the color through
    if (luma == 0) begin
      res.out_red      = px.in_red;
      res.out_green    = px.in_green;
      res.out_blue     = px.in_blue;
      res.divide_error = 1'b1;
      return res;
    end
    // Clamp shifted luma; the upper bound is applied last
    new_luma = luma + longint'($signed(px.luma_shift));
    if (new_luma < longint'(lo)) new_luma = longint'(lo);
    if (new_luma > longint'(hi)) new_luma = longint'(hi);
    co_new = scaled_chroma(co + longint'($signed(px.orange_shift)), luma, new_luma);
    cg_new = scaled_chroma(cg + longint'($signed(px.green_shift)), luma, new_luma);
    res.out_red      = clip_value(new_luma + co_new - cg_new);
    res.out_green    = clip_value(new_luma + cg_new);
    res.out_blue     = clip_value(new_luma - co_new - cg_new);
    res.divide_error = 1'b0;
    return res;
  endfunction

  function automatic pixel_in_t make_pixel(longint red, longint green, longint blue,
                                           longint orange, longint chroma_g, longint luma);
    pixel_in_t px;
    px.in_red       = value_t'(red);
    px.in_green     = value_t'(green);
    px.in_blue      = value_t'(blue);
    px.orange_shift = value_t'(orange);
    px.green_shift  = value_t'(chroma_g);
    px.luma_shift   = value_t'(luma);
    return px;
  endfunction

  // Mix full-range values with plausible colors, signed offsets and corners
  function automatic value_t random_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return value_t'($urandom);
      3, 4, 5: return value_t'($urandom_range(0, 32'(2 * ONE)));
      6, 7:    return value_t'(longint'($urandom_range(0, 32'(4 * ONE))) - 2 * ONE);
      8: begin
        case ($urandom_range(0, 4))
          0:       return value_t'(VALUE_HI);
          1:       return value_t'(VALUE_LO);
          2:       return value_t'(0);
          3:       return value_t'(-1);
          default: return value_t'(1);
        endcase
      end
      default: return value_t'(longint'($urandom_range(0, 32'(ONE / 4))) - ONE / 8);
    endcase
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    longint    blue;
    px.in_red       = random_value();
    px.in_green     = random_value();
    px.in_blue      = random_value();
    px.orange_shift = random_value();
    px.green_shift  = random_value();
    px.luma_shift   = random_value();
    // Now and then pick blue so that the luma floors to zero
    if ($urandom_range(0, 7) == 0) begin
      blue = longint'($urandom_range(0, 3))
             - longint'($signed(px.in_red)) - 2 * longint'($signed(px.in_green));
      if (blue >= VALUE_LO && blue <= VALUE_HI) px.in_blue = value_t'(blue);
    end
    return px;
  endfunction

  task automatic queue_pixel(pixel_in_t px);
    pixel_backlog.push_back(px);
    issued_count++;
  endtask

  task automatic check_field(input string name, input logic signed [VALUE_WIDTH-1:0] want,
                             input logic signed [VALUE_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Write one clamp register; drop valid and wait on a clock edge before returning
  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] reg_index,
                                input luma_t value);
    cfg_valid <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every issued pixel has been checked, then let the pipe settle
  task automatic wait_drained();
    while (checked_count != issued_count) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Track the clamp registers as the block sees them
  always @(posedge clk) begin
    if (rst) begin
      luma_floor   <= '0;
      luma_ceiling <= luma_t'(ONE);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_LUMA: luma_floor   <= cfg_data;
        REG_MAX_LUMA: luma_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // Drive pixels; hold the payload while stalled, predict on each transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_colors.push_back(adjust_color(in_data, luma_floor, luma_ceiling));
      end
      if (!in_valid || !in_stall) begin
        if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pixel_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin : result_monitor
    pixel_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d %0d %0d error %0d",
                   $time, out_data.out_red, out_data.out_green, out_data.out_blue,
                   out_data.divide_error);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          check_field("out_red", want.out_red, out_data.out_red);
          check_field("out_green", want.out_green, out_data.out_green);
          check_field("out_blue", want.out_blue, out_data.out_blue);
          check_field("divide_error", value_t'(want.divide_error),
                      value_t'(out_data.divide_error));
          checked_count++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ycocg_color_shift regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct  = 36;
    recv_stall_pct = 62;

    // Directed pixels under the reset clamps
    queue_pixel(make_pixel(0, 0, 0, 0, 0, 0));
    queue_pixel(make_pixel(3, 0, 0, ONE, -ONE, ONE));
    queue_pixel(make_pixel(0, 1, 0, 0, 0, 0));
    queue_pixel(make_pixel(ONE, -ONE, ONE, ONE / 2, ONE / 2, ONE));
    queue_pixel(make_pixel(ONE, ONE, ONE, 0, 0, 0));
    queue_pixel(make_pixel(ONE / 2, ONE / 2, ONE / 2, 0, 0, 0));
    queue_pixel(make_pixel(ONE, 0, 0, 0, 0, 0));
    queue_pixel(make_pixel(0, ONE, 0, 0, 0, 0));
    queue_pixel(make_pixel(0, 0, ONE, 0, 0, 0));
    queue_pixel(make_pixel(ONE / 2, ONE / 2, ONE / 2, 0, 0, ONE / 4));
    queue_pixel(make_pixel(ONE / 2, ONE / 4, ONE / 8, 0, 0, -ONE));
    queue_pixel(make_pixel(ONE / 2, ONE / 2, ONE / 2, VALUE_HI, 0, 0));
    queue_pixel(make_pixel(ONE / 2, ONE / 2, ONE / 2, 0, VALUE_LO, 0));
    queue_pixel(make_pixel(VALUE_HI, VALUE_HI, VALUE_HI, VALUE_HI, VALUE_HI, VALUE_HI));
    queue_pixel(make_pixel(VALUE_LO, VALUE_LO, VALUE_LO, VALUE_LO, VALUE_LO, VALUE_LO));
    queue_pixel(make_pixel(VALUE_HI, 0, VALUE_LO, 0, 0, 0));
    queue_pixel(make_pixel(VALUE_LO, VALUE_HI, VALUE_LO, 0, 0, 0));
    queue_pixel(make_pixel(-ONE, -ONE / 2, 0, ONE / 4, -ONE / 4, 0));
    queue_pixel(make_pixel(-ONE, -ONE, -ONE, 0, 0, 2 * ONE));
    queue_pixel(make_pixel(ONE, 0, 0, VALUE_LO, VALUE_HI, VALUE_LO));
    queue_pixel(make_pixel(-1, 0, 0, ONE, ONE, 0));
    queue_pixel(make_pixel(VALUE_HI, VALUE_HI, VALUE_LO, VALUE_HI, VALUE_LO, VALUE_HI));
    wait_drained();

    // Random phases, each under its own clamp setting
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph == 2) begin
        send_idle_pct  = 62;
        recv_stall_pct = 36;
      end
      if (ph == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_register(REG_MIN_LUMA, PHASE_MIN[ph]);
      write_register(REG_MAX_LUMA, PHASE_MAX[ph]);
      // Unmapped indexes must leave both clamps alone
      if (ph == PHASE_COUNT - 1) begin
        write_register(REG_SPARE_A, luma_t'($urandom));
        write_register(REG_SPARE_B, luma_t'($urandom));
      end
      repeat (PHASE_ITEMS) queue_pixel(random_pixel());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("ycocg_color_shift regression: pass");
    end else begin
      $display("ycocg_color_shift regression: fail");
    end
    $finish;
  end

endmodule
